### rtl/core/alu_execute_with_flags_macros.svh
// Assertion macros shared by the ALU execute block.
`ifndef ALU_EXECUTE_WITH_FLAGS_MACROS_SVH
`define ALU_EXECUTE_WITH_FLAGS_MACROS_SVH
`ifndef SYNTHESIS
`define AX_ASSERT(lbl, ck, rs, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (prop)) else $error(msg);
`define AX_ASSERT_NEXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) else $error(msg);
`else
`define AX_ASSERT(lbl, ck, rs, prop, msg)
`define AX_ASSERT_NEXT(lbl, ck, rs, ante, cons, msg)
`endif
`endif

### rtl/core/aluex_pkg.sv
// Types, constants and opcodes of the ALU execute block.
package aluex_pkg;

  localparam int REG_COUNT = 32;
  localparam int REG_AW = $clog2(REG_COUNT);
  localparam int DATA_W = 32;
  localparam logic [4:0] DISCARD_REG = 5'd31;
  localparam logic [DATA_W-1:0] WORD_MASK = 32'hFFFF_FFFF;
  localparam logic [DATA_W-1:0] SIGN_BIT = 32'h8000_0000;

  typedef enum logic [3:0] {
    OP_ADD  = 4'd0,
    OP_SUB  = 4'd1,
    OP_ADC  = 4'd2,
    OP_SBC  = 4'd3,
    OP_AND  = 4'd4,
    OP_OR   = 4'd5,
    OP_ORN  = 4'd6,
    OP_EOR  = 4'd7,
    OP_ADDS = 4'd8,
    OP_SUBS = 4'd9,
    OP_ANDS = 4'd10,
    OP_BIC  = 4'd11,
    OP_BICS = 4'd12,
    OP_ADCS = 4'd13,
    OP_SBCS = 4'd14,
    OP_MOVT = 4'd15
  } op_t;

  typedef enum logic [1:0] {
    SH_LSL = 2'd0,
    SH_LSR = 2'd1,
    SH_ASR = 2'd2,
    SH_ROR = 2'd3
  } shift_t;

  typedef struct packed {
    logic [3:0]  op;
    logic [1:0]  shift_kind;
    logic [4:0]  dest_reg;
    logic [4:0]  src_a_reg;
    logic [4:0]  src_b_reg;
    logic [4:0]  shift_amount;
    logic        use_immediate;
    logic [15:0] immediate;
  } in_item_t;

  typedef struct packed {
    logic              write_done;
    logic [4:0]        write_reg;
    logic [DATA_W-1:0] result_value;
    logic              flag_negative;
    logic              flag_zero;
    logic              flag_carry;
    logic              flag_overflow;
  } out_item_t;

  typedef struct packed {
    logic n;
    logic z;
    logic c;
    logic v;
  } flags_t;

  typedef struct packed {
    logic [3:0]  op;
    logic [1:0]  shift_kind;
    logic [4:0]  shift_amount;
    logic        use_immediate;
    logic [15:0] immediate;
  } alu_ctl_t;

  typedef struct packed {
    logic [DATA_W-1:0] result;
    flags_t            flags;
  } alu_res_t;

endpackage

### rtl/core/aluex_in_if.sv
// Valid/ready channel that carries one decoded ALU operation.
interface aluex_in_if;
  logic                valid;
  logic                ready;
  aluex_pkg::in_item_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

### rtl/core/aluex_out_if.sv
// Valid/ready channel that carries one ALU result with its flags.
interface aluex_out_if;
  logic                 valid;
  logic                 ready;
  aluex_pkg::out_item_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

### rtl/core/aluex_ram.sv
// Generic RAM with one write port and two registered read ports.
module aluex_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr0,
  input  logic [$clog2(DEPTH)-1:0] raddr1,
  output logic [WIDTH-1:0]         rdata0,
  output logic [WIDTH-1:0]         rdata1
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata0 <= mem[raddr0];
      rdata1 <= mem[raddr1];
    end
  end

endmodule

### rtl/core/aluex_alu.sv
// Operand shifter, ALU and flag logic for one operation.
module aluex_alu (
  input  aluex_pkg::alu_ctl_t              ctl,
  input  logic [aluex_pkg::DATA_W-1:0]     a,
  input  logic [aluex_pkg::DATA_W-1:0]     b_reg,
  input  aluex_pkg::flags_t                flags,
  output aluex_pkg::alu_res_t              res
);

  logic [aluex_pkg::DATA_W-1:0] shifted;
  logic [aluex_pkg::DATA_W-1:0] b;
  logic [aluex_pkg::DATA_W-1:0] b_add;
  logic                         cin;
  logic [aluex_pkg::DATA_W:0]   sum;
  logic [aluex_pkg::DATA_W-1:0] r;
  logic [5:0]                   rot_left;

  // Operand B: shifted register or zero-extended immediate.
  always_comb begin
    rot_left = 6'd32 - {1'b0, ctl.shift_amount};
    case (ctl.shift_kind)
      aluex_pkg::SH_LSL: shifted = b_reg << ctl.shift_amount;
      aluex_pkg::SH_LSR: shifted = b_reg >> ctl.shift_amount;
      aluex_pkg::SH_ASR: shifted = 32'($signed(b_reg) >>> ctl.shift_amount);
      aluex_pkg::SH_ROR: shifted = (b_reg >> ctl.shift_amount) | (b_reg << rot_left);
      default:           shifted = b_reg;
    endcase
    b = ctl.use_immediate ? {16'h0000, ctl.immediate} : shifted;
  end

  // Adder input selection for the add and subtract families.
  always_comb begin
    case (ctl.op)
      aluex_pkg::OP_SUB, aluex_pkg::OP_SUBS: begin
        b_add = ~b;
        cin   = 1'b1;
      end
      aluex_pkg::OP_SBC, aluex_pkg::OP_SBCS: begin
        b_add = ~b;
        cin   = flags.c;
      end
      aluex_pkg::OP_ADC, aluex_pkg::OP_ADCS: begin
        b_add = b;
        cin   = flags.c;
      end
      default: begin
        b_add = b;
        cin   = 1'b0;
      end
    endcase
    sum = {1'b0, a} + {1'b0, b_add} + {{aluex_pkg::DATA_W{1'b0}}, cin};
  end

  always_comb begin
    res.flags = flags;
    case (ctl.op)
      aluex_pkg::OP_ADD, aluex_pkg::OP_SUB,
      aluex_pkg::OP_ADC, aluex_pkg::OP_SBC: r = sum[aluex_pkg::DATA_W-1:0];
      aluex_pkg::OP_AND:  r = a & b;
      aluex_pkg::OP_OR:   r = a | b;
      aluex_pkg::OP_ORN:  r = a | ~b;
      aluex_pkg::OP_EOR:  r = a ^ b;
      aluex_pkg::OP_ANDS: r = a & b;
      aluex_pkg::OP_BIC,
      aluex_pkg::OP_BICS: r = a & ~b;
      aluex_pkg::OP_ADDS, aluex_pkg::OP_SUBS,
      aluex_pkg::OP_ADCS, aluex_pkg::OP_SBCS: r = sum[aluex_pkg::DATA_W-1:0];
      // For movt, operand A carries the old destination value.
      aluex_pkg::OP_MOVT: r = {ctl.immediate, a[15:0]};
      default:            r = '0;
    endcase

    if (ctl.op inside {aluex_pkg::OP_ADDS, aluex_pkg::OP_SUBS,
                       aluex_pkg::OP_ADCS, aluex_pkg::OP_SBCS}) begin
      res.flags.n = |(r & aluex_pkg::SIGN_BIT);
      res.flags.z = (r == '0);
      res.flags.c = sum[aluex_pkg::DATA_W];
      res.flags.v = |(~(a ^ b_add) & (a ^ r) & aluex_pkg::SIGN_BIT);
    end else if (ctl.op inside {aluex_pkg::OP_ANDS, aluex_pkg::OP_BICS}) begin
      res.flags.n = |(r & aluex_pkg::SIGN_BIT);
      res.flags.z = (r == '0);
    end
    res.result = r & aluex_pkg::WORD_MASK;
  end

endmodule

### rtl/core/alu_execute_with_flags.sv
// Top level of the ALU execute block: register file, operand stage and result register.
// A result passes through the operand stage (register-file read) and then the result register.
// Throughput: one operation per cycle while the result receiver does not hold ready low.
// Back-to-back dependent operations are served by forwarding the most recent write.
// Reset (rst, synchronous, active high) clears the pipeline valids, the NZCV flags and
// one valid flop per register, so every register reads as zero until first written.
`include "alu_execute_with_flags_macros.svh"

module alu_execute_with_flags (
  input  logic           clk,
  input  logic           rst,
  aluex_in_if.sink       issue,
  aluex_out_if.source    result
);

  // Operand stage: the accepted transaction waits here while the register
  // file delivers its registered read data.
  logic                s1_valid;
  aluex_pkg::in_item_t s1_item;
  logic [4:0]          s1_idx0;
  logic                s1_advance;
  logic                s1_sets_flags;

  // Result register.
  logic                 out_valid;
  aluex_pkg::out_item_t out_item;

  aluex_pkg::flags_t flags;
  logic [aluex_pkg::REG_COUNT-1:0] reg_valid;

  // Most recent register write, used to forward into the operand stage.
  logic                         lw_valid;
  logic [4:0]                   lw_reg;
  logic [aluex_pkg::DATA_W-1:0] lw_data;

  logic                         accept;
  logic [4:0]                   rd_idx0;
  logic [aluex_pkg::DATA_W-1:0] rdata0;
  logic [aluex_pkg::DATA_W-1:0] rdata1;
  logic [aluex_pkg::DATA_W-1:0] opnd0;
  logic [aluex_pkg::DATA_W-1:0] opnd1;
  logic                         wr_en;
  logic [aluex_pkg::REG_AW-1:0] wr_addr;

  aluex_pkg::alu_ctl_t alu_ctl;
  aluex_pkg::alu_res_t alu_res;

  // The stage moves forward whenever the result register is free or being drained.
  assign s1_advance  = s1_valid && (!out_valid || result.ready);
  assign issue.ready = !s1_valid || s1_advance;
  assign accept      = issue.valid && issue.ready;

  // movt needs the old destination value instead of operand A, so the first
  // read port is steered to the destination register for it.
  assign rd_idx0 = (issue.data.op == aluex_pkg::OP_MOVT) ? issue.data.dest_reg
                                                         : issue.data.src_a_reg;

  aluex_ram #(
    .WIDTH(aluex_pkg::DATA_W),
    .DEPTH(aluex_pkg::REG_COUNT)
  ) u_regfile (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (alu_res.result),
    .re    (accept),
    .raddr0(aluex_pkg::REG_AW'(rd_idx0)),
    .raddr1(aluex_pkg::REG_AW'(issue.data.src_b_reg)),
    .rdata0(rdata0),
    .rdata1(rdata1)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (issue.ready) begin
      s1_valid <= issue.valid;
    end
    if (accept) begin
      s1_item <= issue.data;
      s1_idx0 <= rd_idx0;
    end
  end

  // Operand resolution. The read data misses only the write that retired at
  // the same edge the transaction was accepted; that write is the newest one
  // and sits in the forwarding register. Registers that were never written,
  // and indexes outside the file, read as zero.
  always_comb begin
    if (lw_valid && lw_reg == s1_idx0) begin
      opnd0 = lw_data;
    end else if (32'(s1_idx0) < aluex_pkg::REG_COUNT
                 && reg_valid[aluex_pkg::REG_AW'(s1_idx0)]) begin
      opnd0 = rdata0;
    end else begin
      opnd0 = '0;
    end
    if (lw_valid && lw_reg == s1_item.src_b_reg) begin
      opnd1 = lw_data;
    end else if (32'(s1_item.src_b_reg) < aluex_pkg::REG_COUNT
                 && reg_valid[aluex_pkg::REG_AW'(s1_item.src_b_reg)]) begin
      opnd1 = rdata1;
    end else begin
      opnd1 = '0;
    end
  end

  always_comb begin
    alu_ctl.op            = s1_item.op;
    alu_ctl.shift_kind    = s1_item.shift_kind;
    alu_ctl.shift_amount  = s1_item.shift_amount;
    alu_ctl.use_immediate = s1_item.use_immediate;
    alu_ctl.immediate     = s1_item.immediate;
    s1_sets_flags = s1_item.op inside {aluex_pkg::OP_ADDS, aluex_pkg::OP_SUBS,
                                       aluex_pkg::OP_ADCS, aluex_pkg::OP_SBCS,
                                       aluex_pkg::OP_ANDS, aluex_pkg::OP_BICS};
  end

  aluex_alu u_alu (
    .ctl  (alu_ctl),
    .a    (opnd0),
    .b_reg(opnd1),
    .flags(flags),
    .res  (alu_res)
  );

  // Writes to the discard register or beyond the file are dropped.
  assign wr_en = s1_advance && s1_item.dest_reg != aluex_pkg::DISCARD_REG
                 && 32'(s1_item.dest_reg) < aluex_pkg::REG_COUNT;
  assign wr_addr = aluex_pkg::REG_AW'(s1_item.dest_reg);

  // Retirement: flags, register valid bits, forwarding register and result.
  always_ff @(posedge clk) begin
    if (rst) begin
      flags     <= '0;
      reg_valid <= '0;
      lw_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_advance) begin
        flags <= alu_res.flags;
      end
      if (wr_en) begin
        reg_valid[wr_addr] <= 1'b1;
        lw_valid           <= 1'b1;
      end
      if (s1_advance) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
    if (wr_en) begin
      lw_reg  <= s1_item.dest_reg;
      lw_data <= alu_res.result;
    end
    if (s1_advance) begin
      out_item.write_done    <= wr_en;
      out_item.write_reg     <= s1_item.dest_reg;
      out_item.result_value  <= alu_res.result;
      out_item.flag_negative <= alu_res.flags.n;
      out_item.flag_zero     <= alu_res.flags.z;
      out_item.flag_carry    <= alu_res.flags.c;
      out_item.flag_overflow <= alu_res.flags.v;
    end
  end

  assign result.valid = out_valid;
  assign result.data  = out_item;

  // A transaction that reports a write never names the discard register.
  `AX_ASSERT(a_no_discard_write, clk, rst, !(out_valid && out_item.write_done) || out_item.write_reg != aluex_pkg::DISCARD_REG, "write reported to discard register")
  // Operations that do not set flags leave them untouched.
  `AX_ASSERT_NEXT(a_flags_hold, clk, rst, s1_advance && !s1_sets_flags, flags == $past(flags), "flags changed by non-flag operation")
  // A retired write marks its register valid.
  `AX_ASSERT_NEXT(a_write_marks_valid, clk, rst, wr_en, reg_valid[$past(wr_addr)], "written register not marked valid")
  // Retirement always presents a result in the next cycle.
  `AX_ASSERT_NEXT(a_retire_gives_result, clk, rst, s1_advance, out_valid, "retired operation left no result")

endmodule

### test/alu_execute_with_flags_test.sv
// Self-checking testbench for the ALU execute block with its register file and NZCV flags.
module alu_execute_with_flags_test;
  timeunit 1ns;
  timeprecision 1ps;

  // Receiver ready patterns. Each pattern holds for a random stretch of cycles.
  typedef enum logic [1:0] {
    RX_STREAM,
    RX_COIN,
    RX_SPARSE,
    RX_PERIODIC
  } rx_mode_t;

  localparam int DIRECTED_RANDOM_SPLIT = 500;
  localparam int RANDOM_OPS = 1000;
  localparam int SETTLE_CYCLES = 8;

  logic clk;
  logic rst;

  aluex_in_if  issue_ch();
  aluex_out_if result_ch();

  alu_execute_with_flags dut (
    .clk    (clk),
    .rst    (rst),
    .issue  (issue_ch),
    .result (result_ch)
  );

  // Operations waiting to be issued. The head is what the driver puts on the bus.
  aluex_pkg::in_item_t  pending_ops[$];
  // Predicted results, oldest first, one per accepted operation.
  aluex_pkg::out_item_t expected_results[$];

  // Shadow copy of the architectural state that the block keeps.
  logic [aluex_pkg::DATA_W-1:0] reg_shadow [aluex_pkg::REG_COUNT];
  aluex_pkg::flags_t            flags_shadow;

  int mismatch_count = 0;
  int ops_issued = 0;
  int results_checked = 0;
  int discard_hits = 0;
  int op_hits [16];

  // Handshake bookkeeping for the driver, sampled at the rising edge.
  logic issue_taken = 1'b0;
  int burst_left = 0;
  int gap_left = 0;

  rx_mode_t rx_mode = RX_STREAM;
  int rx_mode_left = 0;
  logic [2:0] rx_phase = 3'd0;

  // Prints one line per mismatch and counts it.
  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // Computes the result of one operation and advances the shadow registers and flags.
  // Operand B is the immediate or the shifted register; all arithmetic forms are built as
  // a + b' + cin, so sub and sbc simply invert operand B and choose the carry in.
  function automatic aluex_pkg::out_item_t predict_alu(input aluex_pkg::in_item_t op_in);
    logic [aluex_pkg::DATA_W-1:0] a;
    logic [aluex_pkg::DATA_W-1:0] b;
    logic [aluex_pkg::DATA_W-1:0] r;
    logic [aluex_pkg::DATA_W:0]   sum;
    logic [4:0]                   amt;
    logic                         cin;
    logic                         set_all;
    logic                         set_nz;
    aluex_pkg::op_t               op_kind;
    aluex_pkg::out_item_t         res;

    op_kind = aluex_pkg::op_t'(op_in.op);
    a = reg_shadow[op_in.src_a_reg];
    if (op_in.use_immediate) begin
      b = {16'h0000, op_in.immediate};
    end else begin
      b = reg_shadow[op_in.src_b_reg];
      amt = op_in.shift_amount;
      // A zero amount passes the register through for every shift kind.
      if (amt != 5'd0) begin
        case (aluex_pkg::shift_t'(op_in.shift_kind))
          aluex_pkg::SH_LSL: b = b << amt;
          aluex_pkg::SH_LSR: b = b >> amt;
          aluex_pkg::SH_ASR: b = $signed(b) >>> amt;
          default: b = (b >> amt) | (b << (32 - amt));
        endcase
      end
    end

    cin = 1'b0;
    set_all = 1'b0;
    set_nz = 1'b0;
    case (op_kind)
      aluex_pkg::OP_SUB: begin
        b = ~b;
        cin = 1'b1;
      end
      aluex_pkg::OP_ADC: cin = flags_shadow.c;
      aluex_pkg::OP_SBC: begin
        b = ~b;
        cin = flags_shadow.c;
      end
      aluex_pkg::OP_ADDS: set_all = 1'b1;
      aluex_pkg::OP_SUBS: begin
        b = ~b;
        cin = 1'b1;
        set_all = 1'b1;
      end
      aluex_pkg::OP_ADCS: begin
        cin = flags_shadow.c;
        set_all = 1'b1;
      end
      aluex_pkg::OP_SBCS: begin
        b = ~b;
        cin = flags_shadow.c;
        set_all = 1'b1;
      end
      default: ;
    endcase

    sum = {1'b0, a} + {1'b0, b} + {{aluex_pkg::DATA_W{1'b0}}, cin};
    r = sum[aluex_pkg::DATA_W-1:0];
    case (op_kind)
      aluex_pkg::OP_AND: r = a & b;
      aluex_pkg::OP_ANDS: begin
        r = a & b;
        set_nz = 1'b1;
      end
      aluex_pkg::OP_OR:  r = a | b;
      aluex_pkg::OP_ORN: r = a | ~b;
      aluex_pkg::OP_EOR: r = a ^ b;
      aluex_pkg::OP_BIC: r = a & ~b;
      aluex_pkg::OP_BICS: begin
        r = a & ~b;
        set_nz = 1'b1;
      end
      // movt keeps the low half of the destination and ignores all but the immediate.
      aluex_pkg::OP_MOVT: r = {op_in.immediate, reg_shadow[op_in.dest_reg][15:0]};
      default: ;
    endcase

    if (set_all || set_nz) begin
      flags_shadow.n = r[aluex_pkg::DATA_W-1];
      flags_shadow.z = (r == '0);
    end
    if (set_all) begin
      flags_shadow.c = sum[aluex_pkg::DATA_W];
      flags_shadow.v = ~(a[aluex_pkg::DATA_W-1] ^ b[aluex_pkg::DATA_W-1])
                       & (a[aluex_pkg::DATA_W-1] ^ r[aluex_pkg::DATA_W-1]);
    end

    res.write_done = (op_in.dest_reg != aluex_pkg::DISCARD_REG);
    if (res.write_done) begin
      reg_shadow[op_in.dest_reg] = r;
    end
    res.write_reg = op_in.dest_reg;
    res.result_value = r;
    res.flag_negative = flags_shadow.n;
    res.flag_zero = flags_shadow.z;
    res.flag_carry = flags_shadow.c;
    res.flag_overflow = flags_shadow.v;
    return res;
  endfunction

  // Queues one hand-built operation for the directed part.
  task automatic add_op(input aluex_pkg::op_t o, input aluex_pkg::shift_t k, input int dst,
                        input int sa, input int sb, input int amt, input bit imm_sel,
                        input int imm);
    aluex_pkg::in_item_t item;
    item.op = o;
    item.shift_kind = k;
    item.dest_reg = dst[4:0];
    item.src_a_reg = sa[4:0];
    item.src_b_reg = sb[4:0];
    item.shift_amount = amt[4:0];
    item.use_immediate = imm_sel;
    item.immediate = imm[15:0];
    pending_ops.push_back(item);
  endtask

  // Register choice leans on a few low registers so results feed later operations,
  // with the discard register and the full range mixed in.
  function automatic logic [4:0] pick_reg();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return 5'($urandom_range(0, 7));
    if (roll < 80) return aluex_pkg::DISCARD_REG;
    return 5'($urandom_range(0, 31));
  endfunction

  function automatic aluex_pkg::in_item_t random_op();
    aluex_pkg::in_item_t item;
    int roll;
    item.op = 4'($urandom_range(0, 15));
    item.shift_kind = 2'($urandom_range(0, 3));
    item.dest_reg = pick_reg();
    item.src_a_reg = pick_reg();
    item.src_b_reg = pick_reg();
    roll = $urandom_range(0, 99);
    if (roll < 15) item.shift_amount = 5'd0;
    else if (roll < 30) item.shift_amount = 5'd31;
    else item.shift_amount = 5'($urandom_range(0, 31));
    item.use_immediate = ($urandom_range(0, 99) < 30);
    roll = $urandom_range(0, 99);
    if (roll < 20) item.immediate = 16'h0000;
    else if (roll < 40) item.immediate = 16'hFFFF;
    else if (roll < 50) item.immediate = 16'h8000;
    else item.immediate = 16'($urandom_range(0, 65535));
    return item;
  endfunction

  task automatic wait_drained();
    while (pending_ops.size() != 0 || expected_results.size() != 0) begin
      @(posedge clk);
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Generous ceiling: a correct run needs a few tens of microseconds.
  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // Sender. The bus changes only at the falling edge. A transaction that has not been taken
  // stays on the bus unchanged; otherwise the driver works in bursts of random length with
  // random gaps between them, and a zero gap gives a stretch with no idling at all.
  always @(negedge clk) begin
    if (rst) begin
      issue_ch.valid <= 1'b0;
    end else begin
      if (issue_taken && burst_left != 0) begin
        burst_left--;
        if (burst_left == 0) begin
          gap_left = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 8);
        end
      end
      if (issue_ch.valid && !issue_taken) begin
        // The current transaction is still waiting for ready.
      end else if (pending_ops.size() == 0 || (burst_left == 0 && gap_left != 0)) begin
        issue_ch.valid <= 1'b0;
        if (pending_ops.size() != 0) gap_left--;
      end else begin
        if (burst_left == 0) burst_left = $urandom_range(1, 24);
        issue_ch.valid <= 1'b1;
        issue_ch.data <= pending_ops[0];
      end
    end
  end

  // Receiver. Ready follows one of several patterns, each held for a random stretch, so
  // that stalls land on every phase of the two-stage pipeline.
  always @(negedge clk) begin
    if (rx_mode_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      rx_mode_left = $urandom_range(16, 96);
    end else begin
      rx_mode_left--;
    end
    rx_phase = rx_phase + 3'd1;
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_STREAM:   result_ch.ready <= 1'b1;
        RX_COIN:     result_ch.ready <= 1'($urandom_range(0, 1));
        RX_SPARSE:   result_ch.ready <= ($urandom_range(0, 3) == 0);
        default:     result_ch.ready <= (rx_phase[1:0] != 2'd3);
      endcase
    end
  end

  // Monitor. Both channels are sampled at the rising edge. A result is checked before the
  // operation accepted at the same edge is predicted, so the order never matters.
  always @(posedge clk) begin
    aluex_pkg::out_item_t got;
    aluex_pkg::out_item_t want;
    issue_taken <= !rst && issue_ch.valid && issue_ch.ready;
    if (!rst && result_ch.valid && result_ch.ready) begin
      got = result_ch.data;
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("result with nothing outstanding: reg %0d value %08h",
                                  got.write_reg, got.result_value));
      end else begin
        want = expected_results.pop_front();
        if (got.write_done !== want.write_done)
          report_mismatch($sformatf("result %0d write_done got %0b want %0b",
                                    results_checked, got.write_done, want.write_done));
        if (got.write_reg !== want.write_reg)
          report_mismatch($sformatf("result %0d write_reg got %0d want %0d",
                                    results_checked, got.write_reg, want.write_reg));
        if (got.result_value !== want.result_value)
          report_mismatch($sformatf("result %0d result_value got %08h want %08h",
                                    results_checked, got.result_value, want.result_value));
        if (got.flag_negative !== want.flag_negative)
          report_mismatch($sformatf("result %0d flag_negative got %0b want %0b",
                                    results_checked, got.flag_negative, want.flag_negative));
        if (got.flag_zero !== want.flag_zero)
          report_mismatch($sformatf("result %0d flag_zero got %0b want %0b",
                                    results_checked, got.flag_zero, want.flag_zero));
        if (got.flag_carry !== want.flag_carry)
          report_mismatch($sformatf("result %0d flag_carry got %0b want %0b",
                                    results_checked, got.flag_carry, want.flag_carry));
        if (got.flag_overflow !== want.flag_overflow)
          report_mismatch($sformatf("result %0d flag_overflow got %0b want %0b",
                                    results_checked, got.flag_overflow, want.flag_overflow));
        results_checked++;
      end
    end
    if (!rst && issue_ch.valid && issue_ch.ready) begin
      expected_results.push_back(predict_alu(issue_ch.data));
      op_hits[issue_ch.data.op]++;
      if (issue_ch.data.dest_reg == aluex_pkg::DISCARD_REG) discard_hits++;
      ops_issued++;
      void'(pending_ops.pop_front());
    end
  end

  initial begin
    int distinct_ops;

    rst = 1'b1;
    issue_ch.valid = 1'b0;
    issue_ch.data = '0;
    result_ch.ready = 1'b0;
    foreach (reg_shadow[i]) reg_shadow[i] = '0;
    flags_shadow = '0;
    foreach (op_hits[i]) op_hits[i] = 0;

    // Directed part. The first three operations build 0xFFFFFFFF in r1 and 0x80000000 in
    // r2, which then drive the carry, overflow and zero corners and every shift kind.
    add_op(aluex_pkg::OP_MOVT, aluex_pkg::SH_LSL, 1, 0, 0, 0, 1'b0, 16'hFFFF);
    add_op(aluex_pkg::OP_OR,   aluex_pkg::SH_LSL, 1, 1, 0, 0, 1'b1, 16'hFFFF);
    add_op(aluex_pkg::OP_MOVT, aluex_pkg::SH_ROR, 2, 7, 7, 31, 1'b1, 16'h8000);
    // Wrap to zero with carry out.
    add_op(aluex_pkg::OP_ADDS, aluex_pkg::SH_LSL, 3, 1, 0, 0, 1'b1, 16'h0001);
    // Carry in from the previous operation, signed overflow, unshifted register operand.
    add_op(aluex_pkg::OP_ADCS, aluex_pkg::SH_LSL, 4, 2, 2, 0, 1'b0, 16'h0000);
    add_op(aluex_pkg::OP_SUBS, aluex_pkg::SH_LSR, 5, 0, 0, 0, 1'b1, 16'h0000);
    add_op(aluex_pkg::OP_SBCS, aluex_pkg::SH_LSL, 6, 2, 0, 0, 1'b1, 16'h0001);
    add_op(aluex_pkg::OP_ADC,  aluex_pkg::SH_LSR, 7, 1, 1, 31, 1'b0, 16'h0000);
    add_op(aluex_pkg::OP_SBC,  aluex_pkg::SH_ASR, 8, 0, 2, 31, 1'b0, 16'h0000);
    add_op(aluex_pkg::OP_SUB,  aluex_pkg::SH_ROR, 9, 0, 1, 16, 1'b0, 16'h0000);
    add_op(aluex_pkg::OP_AND,  aluex_pkg::SH_ASR, 10, 1, 2, 31, 1'b0, 16'h0000);
    add_op(aluex_pkg::OP_ORN,  aluex_pkg::SH_LSL, 11, 0, 0, 0, 1'b0, 16'h0000);
    add_op(aluex_pkg::OP_EOR,  aluex_pkg::SH_ROR, 12, 1, 2, 1, 1'b0, 16'h0000);
    // Logical flag forms touch only N and Z.
    add_op(aluex_pkg::OP_ANDS, aluex_pkg::SH_LSL, 13, 2, 1, 31, 1'b0, 16'h0000);
    add_op(aluex_pkg::OP_BIC,  aluex_pkg::SH_LSL, 14, 1, 0, 0, 1'b1, 16'hFFFF);
    add_op(aluex_pkg::OP_BICS, aluex_pkg::SH_LSL, 15, 2, 2, 0, 1'b0, 16'h0000);
    // Discard register: no write, but flags still move for flag-setting forms.
    add_op(aluex_pkg::OP_MOVT, aluex_pkg::SH_LSL, 31, 0, 0, 0, 1'b0, 16'hABCD);
    add_op(aluex_pkg::OP_ADDS, aluex_pkg::SH_LSL, 31, 1, 1, 0, 1'b0, 16'h0000);
    add_op(aluex_pkg::OP_ADD,  aluex_pkg::SH_LSL, 16, 0, 6, 31, 1'b0, 16'h0000);
    // Zero shift amount passes the register through for logical right and rotate.
    add_op(aluex_pkg::OP_ADD,  aluex_pkg::SH_LSR, 17, 0, 2, 0, 1'b0, 16'h0000);
    add_op(aluex_pkg::OP_EOR,  aluex_pkg::SH_ROR, 18, 0, 1, 0, 1'b0, 16'h0000);
    add_op(aluex_pkg::OP_ADD,  aluex_pkg::SH_ASR, 19, 0, 6, 4, 1'b0, 16'h0000);
    add_op(aluex_pkg::OP_SUBS, aluex_pkg::SH_LSL, 20, 2, 6, 0, 1'b0, 16'h0000);
    add_op(aluex_pkg::OP_MOVT, aluex_pkg::SH_LSL, 20, 3, 4, 5, 1'b1, 16'h0000);
    add_op(aluex_pkg::OP_ADD,  aluex_pkg::SH_LSL, 21, 31, 31, 0, 1'b0, 16'h0000);

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Let the directed part finish completely: the sender sits idle until every
    // expected result has come back.
    wait_drained();

    for (int i = 0; i < DIRECTED_RANDOM_SPLIT; i++) pending_ops.push_back(random_op());
    wait_drained();
    for (int i = DIRECTED_RANDOM_SPLIT; i < RANDOM_OPS; i++) pending_ops.push_back(random_op());
    wait_drained();

    // A few more cycles so that any stray result would still be seen by the monitor.
    repeat (SETTLE_CYCLES) @(posedge clk);

    distinct_ops = 0;
    foreach (op_hits[i]) if (op_hits[i] != 0) distinct_ops++;
    $display("Summary: %0d operations issued, %0d results checked, %0d of 16 opcodes used.",
             ops_issued, results_checked, distinct_ops);
    $display("Summary: %0d operations targeted the discard register; %0d mismatches.",
             discard_hits, mismatch_count);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### files.f
+incdir+rtl/core
rtl/core/aluex_pkg.sv
rtl/core/aluex_in_if.sv
rtl/core/aluex_out_if.sv
rtl/core/aluex_ram.sv
rtl/core/aluex_alu.sv
rtl/core/alu_execute_with_flags.sv
test/alu_execute_with_flags_test.sv
